### hw/rtl/baro_temp_pressure_compensation_core_assert.svh
// Assertion macros for the compensation core.
// Depends on clk and rst_n being visible at the point of use.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BTPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BTPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/btpc_pkg.sv
// Shared types and constants for the barometric compensation core.
// No dependencies.
package btpc_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_CAL_TEMP    = 3'd0;
  localparam logic [2:0] CFG_CAL_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_CAL_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_CAL_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_CAL_PRESS_D = 3'd4;
  localparam logic [2:0] CFG_CAL_PRESS_E = 3'd5;

  // Arithmetic constants of the compensation
  localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
  localparam logic signed [31:0] TEMP_ROUND  = 32'sd128;
  localparam logic [11:0]        PRESS_SCALE = 12'd3125;
  localparam logic [63:0]        X_BIAS      = 64'h0000_8000_0000_0000;

  // Divider geometry: one quotient bit per cell
  localparam int DIV_STEPS = 64;
  localparam int DIV_W     = 31;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centideg;
    logic signed [31:0] fine_temp;
    logic [31:0]        press_q24_8;
    logic               press_invalid;
  } out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Results that ride alongside the pressure path
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        invalid;
  } side_t;

  // State handed from one divider cell to the next
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [63:0]      num;
    logic [DIV_W-1:0] md;
    logic             neg;
    side_t            side;
  } div_t;

endpackage

### hw/rtl/btpc_front.sv
// Temperature path and pressure polynomial up to the divider entry.
// Depends on btpc_pkg.
module btpc_front #(
  parameter int unsigned RAW_FULL_SCALE = 1048576
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  btpc_pkg::in_t   in_data,
  input  btpc_pkg::cal_t  cal,
  output logic            out_vld,
  output btpc_pkg::div_t  out_d
);
  import btpc_pkg::*;

  localparam int NST = 15;

  logic [NST-1:0]     vld_r;
  logic signed [17:0] a_r;
  logic signed [16:0] b_r;
  logic signed [21:0] pd_r [0:10];
  logic signed [33:0] m1_r;
  logic signed [33:0] bb_r;
  logic signed [31:0] v1t_r [0:1];
  logic signed [19:0] bs_r;
  logic signed [35:0] m3_r;
  logic signed [31:0] fine_r;
  side_t              tf_r [0:8];
  logic signed [32:0] v1_r;
  logic [32:0]        mag_r;
  logic [31:0]        hh_r;
  logic [32:0]        hl_r;
  logic [33:0]        ll_r;
  logic signed [48:0] a5_r;
  logic signed [48:0] a2_r;
  logic [63:0]        sq_r;
  logic [63:0]        a5s_r [0:2];
  logic [63:0]        a2s_r [0:2];
  logic signed [48:0] lo6_r;
  logic signed [48:0] lo3_r;
  logic [31:0]        hi6_r;
  logic [31:0]        hi3_r;
  logic [63:0]        a6_r;
  logic signed [63:0] a3_r;
  logic [63:0]        v2_r;
  logic [63:0]        x_r;
  logic signed [49:0] xl_r;
  logic [31:0]        xh_r;
  logic [63:0]        np_r;
  logic signed [30:0] d_r;
  logic [43:0]        nl_r;
  logic [31:0]        nh_r;
  logic [63:0]        n_r;
  logic signed [30:0] d2_r;
  logic               inv_r;
  div_t               out_d_r;

  logic signed [31:0] t5_c;
  logic signed [31:0] temp_c;
  logic signed [32:0] v1_c;
  logic [32:0]        mag_c;
  logic [63:0]        xp_c;
  logic [63:0]        mn_c;
  logic [DIV_W-1:0]   md_c;

  // Advance the valid marks with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Temperature scaling, offset fine term and its magnitude
  always_comb begin
    t5_c   = fine_r + (fine_r <<< 2) + TEMP_ROUND;
    temp_c = t5_c >>> 8;
    v1_c   = 33'(fine_r) - FINE_OFFSET;
    mag_c  = v1_c[32] ? 33'(-v1_c) : 33'(v1_c);
  end

  // Divisor from the P1 product, numerator and divisor magnitudes
  always_comb begin
    xp_c = 64'(xl_r) + {xh_r, 32'b0};
    mn_c = n_r[63] ? (64'd0 - n_r) : n_r;
    md_c = d2_r[30] ? DIV_W'(-d2_r) : DIV_W'(d2_r);
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets
      a_r      <= $signed({1'b0, in_data.raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      b_r      <= $signed({1'b0, in_data.raw_temp[19:4]}) - $signed({1'b0, cal.t1});
      pd_r[0]  <= $signed(22'(RAW_FULL_SCALE)) - $signed({2'b00, in_data.raw_press});
      for (int k = 1; k <= 10; k++) begin
        pd_r[k] <= pd_r[k-1];
      end
      // stage 2: first temperature products
      m1_r     <= a_r * $signed(cal.t2);
      bb_r     <= b_r * b_r;
      // stage 3: 32-bit wrap and shifts
      v1t_r[0] <= $signed(m1_r[31:0]) >>> 11;
      bs_r     <= 20'($signed(bb_r[31:0]) >>> 12);
      // stage 4
      v1t_r[1] <= v1t_r[0];
      m3_r     <= bs_r * $signed(cal.t3);
      // stage 5: fine temperature
      fine_r   <= v1t_r[1] + ($signed(m3_r[31:0]) >>> 14);
      // stage 6: temperature result and pressure offset
      tf_r[0]  <= side_t'{temp: temp_c, fine: fine_r, invalid: 1'b0};
      for (int k = 1; k <= 8; k++) begin
        tf_r[k] <= tf_r[k-1];
      end
      v1_r     <= v1_c;
      mag_r    <= mag_c;
      // stage 7: square partials and linear terms
      hh_r     <= mag_r[32:17] * mag_r[32:17];
      hl_r     <= mag_r[32:17] * mag_r[16:0];
      ll_r     <= mag_r[16:0] * mag_r[16:0];
      a5_r     <= v1_r * $signed(cal.p5);
      a2_r     <= v1_r * $signed(cal.p2);
      // stage 8: square, shifted linear terms
      sq_r     <= (64'(hh_r) << 34) + (64'(hl_r) << 18) + 64'(ll_r);
      a5s_r[0] <= 64'(a5_r) << 17;
      a2s_r[0] <= 64'(a2_r) << 12;
      a5s_r[1] <= a5s_r[0];
      a2s_r[1] <= a2s_r[0];
      a5s_r[2] <= a5s_r[1];
      a2s_r[2] <= a2s_r[1];
      // stage 9: square times P6 and P3, split in halves
      lo6_r    <= $signed({1'b0, sq_r[31:0]}) * $signed(cal.p6);
      hi6_r    <= sq_r[63:32] * 32'($signed(cal.p6));
      lo3_r    <= $signed({1'b0, sq_r[31:0]}) * $signed(cal.p3);
      hi3_r    <= sq_r[63:32] * 32'($signed(cal.p3));
      // stage 10: join halves
      a6_r     <= 64'(lo6_r) + {hi6_r, 32'b0};
      a3_r     <= $signed(64'(lo3_r) + {hi3_r, 32'b0});
      // stage 11: var2 and biased var1
      v2_r     <= a6_r + a5s_r[2] + (64'($signed(cal.p4)) << 35);
      x_r      <= X_BIAS + 64'(a3_r >>> 8) + a2s_r[2];
      // stage 12: times P1, numerator before scaling
      xl_r     <= $signed({1'b0, x_r[31:0]}) * $signed({1'b0, cal.p1});
      xh_r     <= x_r[63:32] * {16'b0, cal.p1};
      np_r     <= (64'(pd_r[10]) << 31) - v2_r;
      // stage 13: divisor, numerator scaling partials
      d_r      <= $signed(xp_c[63:33]);
      nl_r     <= np_r[31:0] * PRESS_SCALE;
      nh_r     <= np_r[63:32] * 32'(PRESS_SCALE);
      // stage 14: numerator, zero divisor flag
      n_r      <= 64'(nl_r) + {nh_r, 32'b0};
      d2_r     <= d_r;
      inv_r    <= (d_r == '0);
      // stage 15: divider entry
      out_d_r  <= div_t'{rem: '0, num: mn_c, md: md_c, neg: n_r[63] ^ d2_r[30],
                         side: side_t'{temp: tf_r[8].temp, fine: tf_r[8].fine,
                                       invalid: inv_r}};
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_d   = out_d_r;

endmodule

### hw/rtl/btpc_div_cell.sv
// One restoring-division cell: produces one quotient bit per request.
// Depends on btpc_pkg.
module btpc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  btpc_pkg::div_t in_d,
  output logic           out_vld,
  output btpc_pkg::div_t out_d
);
  import btpc_pkg::*;

  logic             vld_r;
  div_t             d_r;
  logic [DIV_W:0]   trial_c;
  logic [DIV_W:0]   diff_c;
  logic             ge_c;
  div_t             d_nxt;

  // Shift in the next numerator bit, compare and subtract
  always_comb begin
    trial_c    = {in_d.rem, in_d.num[63]};
    diff_c     = trial_c - {1'b0, in_d.md};
    ge_c       = (trial_c >= {1'b0, in_d.md});
    d_nxt      = in_d;
    d_nxt.rem  = ge_c ? diff_c[DIV_W-1:0] : trial_c[DIV_W-1:0];
    d_nxt.num  = {in_d.num[62:0], ge_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

### hw/rtl/btpc_back.sv
// Quotient sign fix, pressure correction terms and final Q24.8 result.
// Depends on btpc_pkg.
module btpc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  btpc_pkg::div_t  in_d,
  input  btpc_pkg::cal_t  cal,
  output logic            out_vld,
  output btpc_pkg::out_t  out_d
);
  import btpc_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0]     vld_r;
  side_t              sb_r [0:5];
  logic signed [63:0] q_r [0:4];
  logic signed [63:0] ps_r [0:1];
  logic signed [48:0] l9_r;
  logic [31:0]        h9_r;
  logic signed [48:0] l8_r;
  logic [31:0]        h8_r;
  logic [63:0]        t9_r;
  logic signed [63:0] v2f_r [0:2];
  logic [63:0]        ll_r;
  logic [31:0]        lh_r;
  logic [31:0]        hl_r;
  logic signed [63:0] v1f_r;
  logic [63:0]        s_r;
  out_t               out_d_r;

  logic signed [63:0] ps_c;
  logic signed [63:0] v2f_c;
  logic [63:0]        pr_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_comb begin
    ps_c  = q_r[0] >>> 13;
    v2f_c = $signed(64'(l8_r) + {h8_r, 32'b0});
    pr_c  = ll_r + {lh_r + hl_r, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0]  <= in_d.side;
      for (int k = 1; k <= 5; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      // stage 1: apply the quotient sign
      q_r[0]   <= in_d.neg ? $signed(64'd0 - in_d.num) : $signed(in_d.num);
      for (int k = 1; k <= 4; k++) begin
        q_r[k] <= q_r[k-1];
      end
      // stage 2: P9 and P8 products, split in halves
      ps_r[0]  <= ps_c;
      ps_r[1]  <= ps_r[0];
      l9_r     <= $signed({1'b0, ps_c[31:0]}) * $signed(cal.p9);
      h9_r     <= ps_c[63:32] * 32'($signed(cal.p9));
      l8_r     <= $signed({1'b0, q_r[0][31:0]}) * $signed(cal.p8);
      h8_r     <= q_r[0][63:32] * 32'($signed(cal.p8));
      // stage 3: join halves
      t9_r     <= 64'(l9_r) + {h9_r, 32'b0};
      v2f_r[0] <= v2f_c >>> 19;
      v2f_r[1] <= v2f_r[0];
      v2f_r[2] <= v2f_r[1];
      // stage 4: second factor of the square term
      ll_r     <= t9_r[31:0] * ps_r[1][31:0];
      lh_r     <= t9_r[31:0] * ps_r[1][63:32];
      hl_r     <= t9_r[63:32] * ps_r[1][31:0];
      // stage 5
      v1f_r    <= $signed(pr_c) >>> 25;
      // stage 6: sum of terms
      s_r      <= q_r[4] + v1f_r + v2f_r[2];
      // stage 7: scale and add P7 offset, zero on invalid divisor
      out_d_r.temp_centideg <= sb_r[5].temp;
      out_d_r.fine_temp     <= sb_r[5].fine;
      out_d_r.press_invalid <= sb_r[5].invalid;
      out_d_r.press_q24_8   <= sb_r[5].invalid ? 32'd0
                               : s_r[39:8] + (32'($signed(cal.p7)) << 4);
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_d   = out_d_r;

endmodule

### hw/rtl/baro_temp_pressure_compensation_core.sv
// Top level of the barometric compensation core: calibration registers,
// front datapath, divider cell chain, back datapath and result register.
// Depends on btpc_pkg, btpc_front, btpc_div_cell, btpc_back and baro_temp_pressure_compensation_core_assert.svh.

// Takes one raw temperature/pressure pair per cycle while not stalled and
// returns one result per pair, in order, through 15 front stages, a chain of
// 64 division cells that settles one quotient bit each, 7 back stages and the
// result register. The cell chain is the longest part of the path; throughput
// is one pair per clock unless stalled. A stalled result holds the whole
// pipeline once its last stage is also full. Calibration writes complete in
// the cycle they are presented and must only be made while the core is idle.
module baro_temp_pressure_compensation_core #(
  parameter int unsigned RAW_FULL_SCALE = 1048576
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  btpc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output btpc_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data
);
  import btpc_pkg::*;

  logic [47:0] cal_temp_r;
  logic [31:0] cal_press_a_r;
  logic [31:0] cal_press_b_r;
  logic [31:0] cal_press_c_r;
  logic [31:0] cal_press_d_r;
  logic [15:0] cal_press_e_r;
  cal_t        cal;

  logic        en_c;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        back_vld;
  out_t        back_d;
  logic        load_c;

  logic        cv [0:DIV_STEPS];
  div_t        cd [0:DIV_STEPS];

  // Calibration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
      cal_press_d_r <= '0;
      cal_press_e_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAL_TEMP:    cal_temp_r    <= cfg_data;
        CFG_CAL_PRESS_A: cal_press_a_r <= cfg_data[31:0];
        CFG_CAL_PRESS_B: cal_press_b_r <= cfg_data[31:0];
        CFG_CAL_PRESS_C: cal_press_c_r <= cfg_data[31:0];
        CFG_CAL_PRESS_D: cal_press_d_r <= cfg_data[31:0];
        CFG_CAL_PRESS_E: cal_press_e_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Unpack the coefficients
  always_comb begin
    cal.t1 = cal_temp_r[15:0];
    cal.t2 = cal_temp_r[31:16];
    cal.t3 = cal_temp_r[47:32];
    cal.p1 = cal_press_a_r[15:0];
    cal.p2 = cal_press_a_r[31:16];
    cal.p3 = cal_press_b_r[15:0];
    cal.p4 = cal_press_b_r[31:16];
    cal.p5 = cal_press_c_r[15:0];
    cal.p6 = cal_press_c_r[31:16];
    cal.p7 = cal_press_d_r[15:0];
    cal.p8 = cal_press_d_r[31:16];
    cal.p9 = cal_press_e_r;
  end

  // Advance while the result register is free or the last stage is empty
  assign en_c     = !out_valid_r || out_ready || !back_vld;
  assign in_ready = en_c;
  assign load_c   = back_vld && (!out_valid_r || out_ready);

  btpc_front #(
    .RAW_FULL_SCALE (RAW_FULL_SCALE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en_c),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cal      (cal),
    .out_vld  (cv[0]),
    .out_d    (cd[0])
  );

  // Divider cell chain
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    btpc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en_c),
      .in_vld  (cv[g]),
      .in_d    (cd[g]),
      .out_vld (cv[g+1]),
      .out_d   (cd[g+1])
    );
  end

  btpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en_c),
    .in_vld  (cv[DIV_STEPS]),
    .in_d    (cd[DIV_STEPS]),
    .cal     (cal),
    .out_vld (back_vld),
    .out_d   (back_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      out_data_r <= back_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "baro_temp_pressure_compensation_core_assert.svh"

  `BTPC_ASSERT_IMP(a_invalid_zero, out_valid_r && out_data_r.press_invalid,
                   out_data_r.press_q24_8 == 32'd0, "invalid request carries pressure")
  `BTPC_ASSERT_NXT(a_last_holds, back_vld && out_valid_r && !out_ready,
                   back_vld, "last stage lost a request under stall")
  `BTPC_ASSERT_IMP(a_stall_cause, in_valid && !in_ready,
                   out_valid_r && !out_ready && back_vld, "input stalled without cause")

endmodule

### verif/baro_temp_pressure_compensation_core_test.sv
// Self-checking bench for the barometric compensation core: random and directed
// raw pairs under several calibration sets, results checked in order.
// Depends on btpc_pkg and baro_temp_pressure_compensation_core.
module baro_temp_pressure_compensation_core_test;
  import btpc_pkg::*;

  localparam int RAW_FULL_SCALE = 1048576;
  localparam int PIPE_LATENCY   = 90;
  localparam int CYCLE_LIMIT    = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  baro_temp_pressure_compensation_core #(.RAW_FULL_SCALE(RAW_FULL_SCALE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Calibration copy held by the bench
  logic [47:0] cal_temp_q;
  logic [31:0] cal_pa_q, cal_pb_q, cal_pc_q, cal_pd_q;
  logic [15:0] cal_pe_q;

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   error_count;
  int   result_count;
  int   cycle_count;
  bit   stall_hold;       // long receiver hold-off requested
  bit   sender_pause;     // stop offering requests
  int   inv_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Fixed-point compensation of one raw pair under the current calibration
  function automatic out_t compensate(in_t req);
    out_t r;
    logic [31:0] t1, t2, t3, a, b, v1t, v2t, fine, temp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x1, x2, pr, ps, num, den, q;
    t1 = {16'd0, cal_temp_q[15:0]};
    t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
    t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
    p1 = {48'd0, cal_pa_q[15:0]};
    p2 = sx16(cal_pa_q[31:16]);
    p3 = sx16(cal_pb_q[15:0]);
    p4 = sx16(cal_pb_q[31:16]);
    p5 = sx16(cal_pc_q[15:0]);
    p6 = sx16(cal_pc_q[31:16]);
    p7 = sx16(cal_pd_q[15:0]);
    p8 = sx16(cal_pd_q[31:16]);
    p9 = sx16(cal_pe_q);
    a    = {15'd0, req.raw_temp[19:3]} - (t1 << 1);
    v1t  = 32'($signed(a * t2) >>> 11);
    b    = {16'd0, req.raw_temp[19:4]} - t1;
    v2t  = 32'($signed(b * b) >>> 12);
    v2t  = 32'($signed(v2t * t3) >>> 14);
    fine = v1t + v2t;
    temp = 32'($signed(fine * 32'd5 + 32'd128) >>> 8);
    r.temp_centideg = temp;
    r.fine_temp     = fine;
    r.press_q24_8   = '0;
    r.press_invalid = 1'b0;
    x1 = {{32{fine[31]}}, fine} - 64'd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = 64'($signed(x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
    den = 64'($signed(((64'd1 << 47) + x1) * p1) >>> 33);
    if (den == 64'd0) begin
      r.press_invalid = 1'b1;
    end else begin
      pr  = 64'(RAW_FULL_SCALE) - {44'd0, req.raw_press};
      num = ((pr << 31) - x2) * 64'd3125;
      // truncating signed divide, most negative / -1 wraps
      q  = (num[63] ? -num : num) / (den[63] ? -den : den);
      pr = (num[63] != den[63]) ? -q : q;
      ps = 64'($signed(pr) >>> 13);
      x1 = 64'($signed(p9 * ps * ps) >>> 25);
      x2 = 64'($signed(p8 * pr) >>> 19);
      pr = 64'($signed(pr + x1 + x2) >>> 8) + (p7 << 4);
      r.press_q24_8 = pr[31:0];
    end
    return r;
  endfunction

  // Driver: bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !sender_pause) begin
          in_data  <= pending_reqs[0];
          expected_results.push_back(compensate(pending_reqs[0]));
          void'(pending_reqs.pop_front());
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern plus an occasional long hold-off
  int stall_phase, hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_phase <= 0;
      hold_cnt    <= 0;
    end else if (stall_hold && hold_cnt < 300) begin
      hold_cnt  <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
      if (!stall_hold) hold_cnt <= 0;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count <= error_count + 1;
      end else begin
        if (out_data !== expected_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time,
                   expected_results[0], out_data);
          error_count <= error_count + 1;
        end
        if (out_data.press_invalid) inv_seen <= inv_seen + 1;
        void'(expected_results.pop_front());
        result_count <= result_count + 1;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_cal(logic [2:0] idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CAL_TEMP:    cal_temp_q = val;
      CFG_CAL_PRESS_A: cal_pa_q   = val[31:0];
      CFG_CAL_PRESS_B: cal_pb_q   = val[31:0];
      CFG_CAL_PRESS_C: cal_pc_q   = val[31:0];
      CFG_CAL_PRESS_D: cal_pd_q   = val[31:0];
      CFG_CAL_PRESS_E: cal_pe_q   = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c, logic [31:0] d, logic [15:0] e);
    write_cal(CFG_CAL_TEMP, tc);
    write_cal(CFG_CAL_PRESS_A, {16'd0, a});
    write_cal(CFG_CAL_PRESS_B, {16'd0, b});
    write_cal(CFG_CAL_PRESS_C, {16'd0, c});
    write_cal(CFG_CAL_PRESS_D, {16'd0, d});
    write_cal(CFG_CAL_PRESS_E, {32'd0, e});
  endtask

  // Wait for the pipeline to empty before touching calibration
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    in_t r;
    repeat (n) begin
      r.raw_temp  = 20'($urandom);
      r.raw_press = 20'($urandom);
      if ($urandom_range(0, 9) == 0) r.raw_temp = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      if ($urandom_range(0, 9) == 0) r.raw_press = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    in_t r;
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    stall_hold = 1'b0; sender_pause = 1'b0;
    error_count = 0; result_count = 0; cycle_count = 0; inv_seen = 0;
    cal_temp_q = '0; cal_pa_q = '0; cal_pb_q = '0; cal_pc_q = '0;
    cal_pd_q = '0; cal_pe_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: divisor zero, pressure flagged invalid
    r = '{raw_temp: 20'h0, raw_press: 20'h0};          pending_reqs.push_back(r);
    r = '{raw_temp: 20'hFFFFF, raw_press: 20'hFFFFF};  pending_reqs.push_back(r);
    drain();

    // Typical sensor calibration, extremes of raw fields
    load_cal({16'hFC18, 16'h6A24, 16'd27504}, {16'hD5D0, 16'd36477},
             {16'h0D0B, 16'h0BBD}, {16'h1D8B, 16'hFF79}, {16'h3C70, 16'h000F},
             16'h1770);
    for (int i = 0; i < 20; i++) begin
      r = '{raw_temp: 20'(1 << i), raw_press: ~20'(1 << i)};
      pending_reqs.push_back(r);
    end
    r = '{raw_temp: 20'd519888, raw_press: 20'd415148}; pending_reqs.push_back(r);
    queue_random(250);
    // hold off the receiver so the pipeline backs up
    stall_hold = 1'b1;
    drain();
    stall_hold = 1'b0;

    // Extreme coefficients, all ones then sign extremes
    load_cal(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 16'hFFFF);
    queue_random(150);
    // let requests enter the pipeline, then pause the sender until everything has come back
    repeat (60) @(posedge clk);
    sender_pause = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    sender_pause = 1'b0;
    drain();
    load_cal(48'h8000_7FFF_FFFF, 32'h8000_0001, 32'h7FFF_8000, 32'h8000_7FFF,
             32'h7FFF_8000, 16'h8000);
    queue_random(150);
    drain();

    // Random calibration sets, some with p1 zero
    repeat (4) begin
      load_cal({$urandom, 16'($urandom)}, $urandom,
               $urandom, $urandom, $urandom, 16'($urandom));
      if ($urandom_range(0, 3) == 0) write_cal(CFG_CAL_PRESS_A, {16'd0, 16'($urandom), 16'd0});
      queue_random(120);
      drain();
    end

    $display("Covered %0d results across 8 calibration sets, %0d with invalid pressure.",
             result_count, inv_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
